// ===== src/gcn_pkg.sv =====
// ----------------------------------------------------------------------------
// gcn_pkg: shared types and codes for the grid cursor navigator
// Item structs for the event and result channels, key codes, register
// indexes and mode codes.
// ----------------------------------------------------------------------------
`default_nettype none

package gcn_pkg;

  // Grid geometry
  localparam int GRID_SIDE = 8;
  localparam int COORD_W   = 3;

  // Key event codes
  localparam logic [3:0] KIND_UP       = 4'd0;
  localparam logic [3:0] KIND_DOWN     = 4'd1;
  localparam logic [3:0] KIND_LEFT     = 4'd2;
  localparam logic [3:0] KIND_RIGHT    = 4'd3;
  localparam logic [3:0] KIND_SELECT   = 4'd4;
  localparam logic [3:0] KIND_RESELECT = 4'd5;
  localparam logic [3:0] KIND_ACTIVATE = 4'd6;
  localparam logic [3:0] KIND_APPLY    = 4'd7;
  localparam logic [3:0] KIND_PLACE    = 4'd8;

  // Configuration register indexes
  localparam logic [2:0] CFG_MODE    = 3'd0;
  localparam logic [2:0] CFG_LEFT    = 3'd1;
  localparam logic [2:0] CFG_RIGHT   = 3'd2;
  localparam logic [2:0] CFG_TOP     = 3'd3;
  localparam logic [2:0] CFG_BOTTOM  = 3'd4;
  localparam logic [2:0] CFG_WRAP    = 3'd5;
  localparam logic [2:0] CFG_JUMP    = 3'd6;
  localparam logic [2:0] CFG_BLOCKED = 3'd7;

  // Modes up to this one need activation
  localparam logic [2:0] MODE_LAST_ACT = 3'd2;

  // Selection behavior derived from the mode
  localparam logic [1:0] SK_SELDESEL = 2'd0;
  localparam logic [1:0] SK_SELECT   = 2'd1;
  localparam logic [1:0] SK_ON_MOVE  = 2'd2;
  localparam logic [1:0] SK_NONE     = 2'd3;

  typedef struct packed {
    logic [3:0]         kind;
    logic [COORD_W-1:0] target_x;
    logic [COORD_W-1:0] target_y;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] cursor_x;
    logic [COORD_W-1:0] cursor_y;
    logic [COORD_W-1:0] chosen_x;
    logic [COORD_W-1:0] chosen_y;
    logic               chosen_valid;
    logic               cursor_active;
    logic               cursor_moved;
  } out_item_t;

  // Selection state touched by a select
  typedef struct packed {
    logic [COORD_W-1:0] pick_x;
    logic [COORD_W-1:0] pick_y;
    logic               pick_flag;
    logic [COORD_W-1:0] prior_x;
    logic [COORD_W-1:0] prior_y;
    logic               prior_flag;
  } sel_state_t;

endpackage

`default_nettype wire

// ===== src/grid_cursor_navigator_core.sv =====
// ----------------------------------------------------------------------------
// grid_cursor_navigator_core: keypad cursor on a bounded 8x8 grid
// Takes one key event per item and returns the cursor, selection and
// activity state after it. Moves walk the box one cell per cycle.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_stall  in_data  (in_item_t)
//  out_     output     out_valid / out_stall out_data (out_item_t)
//  cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Non-move items are accepted, then their result loads the result register.
// Move items with an active cursor first run the step unit: it visits one cell
// per step and ends a pass at the box edge, or at a wall unless jump is set;
// with wrap set, a second pass re-enters from the opposite edge.
// Reset clears cursor, selection and activity and loads register defaults.
// The output register lets a new item start while a result waits; a full
// register holds the sequencer in its last state, which stalls the input.
//
`default_nettype none

module grid_cursor_navigator_core
  import gcn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_STEP, S_EMIT} state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [2:0]  mode_r, left_r, right_r, top_r, bottom_r;
  logic        wrap_r, jump_r;
  logic [63:0] blocked_r;

  // Navigator state
  logic [COORD_W-1:0] pos_x_r, pos_y_r, pos_x_nxt, pos_y_nxt;
  sel_state_t         sel_r, sel_nxt;
  logic               live_r, live_nxt;
  logic               moved_r, moved_nxt;

  // Result register
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;
  logic               load_out;

  // Step unit state
  logic signed [4:0] nx_r, ny_r, nx_nxt, ny_nxt;
  logic [1:0]        dir_r, dir_nxt;
  logic              pass_r, pass_nxt;

  // Derived box and mode
  logic [2:0]        xmin, xmax, ymin, ymax;
  logic [1:0]        sk;
  logic signed [4:0] dx, dy, cand_x, cand_y;
  logic signed [4:0] sxmin, sxmax, symin, symax;
  logic              cand_in_box, cand_blocked;
  logic              in_acc, out_acc;

  // Saturate an edge value to the grid
  function automatic logic [2:0] sat_edge(input logic [2:0] v);
    sat_edge = (v > 3'(GRID_SIDE - 1)) ? 3'(GRID_SIDE - 1) : v;
  endfunction

  // Map mode to selection behavior
  function automatic logic [1:0] sel_kind(input logic [2:0] m);
    logic [1:0] r;
    case (m)
      3'd0, 3'd4: r = SK_SELDESEL;
      3'd1, 3'd5: r = SK_SELECT;
      3'd2, 3'd3: r = SK_ON_MOVE;
      default:    r = SK_NONE;
    endcase
    sel_kind = r;
  endfunction

  // Select the cursor cell, or deselect it in select/deselect modes if it is the pick
  function automatic sel_state_t do_select(input sel_state_t s,
                                           input logic [2:0] px,
                                           input logic [2:0] py,
                                           input logic live,
                                           input logic [1:0] k);
    sel_state_t r;
    r = s;
    if (live && k != SK_NONE) begin
      if (k == SK_SELDESEL && s.pick_flag && s.pick_x == px && s.pick_y == py) begin
        r.pick_flag = 1'b0;
      end else begin
        r.pick_x     = px;
        r.pick_y     = py;
        r.pick_flag  = 1'b1;
        r.prior_x    = px;
        r.prior_y    = py;
        r.prior_flag = 1'b1;
      end
    end
    do_select = r;
  endfunction

  // Check that a target cell may take the cursor
  function automatic logic can_place(input logic [2:0] tx, input logic [2:0] ty,
                                     input logic [2:0] x0, input logic [2:0] x1,
                                     input logic [2:0] y0, input logic [2:0] y1,
                                     input logic [63:0] blk);
    can_place = (tx >= x0) && (tx <= x1) && (ty >= y0) && (ty <= y1) &&
                !blk[{ty, tx}];
  endfunction

  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;
  assign load_out  = (state_r == S_EMIT) && (!out_valid_r || !out_stall);

  // Order the box bounds
  always_comb begin
    logic [2:0] l, r, t, b;
    l = sat_edge(left_r);
    r = sat_edge(right_r);
    t = sat_edge(top_r);
    b = sat_edge(bottom_r);
    xmin = (l < r) ? l : r;
    xmax = (l < r) ? r : l;
    ymin = (t < b) ? t : b;
    ymax = (t < b) ? b : t;
  end

  assign sk    = sel_kind(mode_r);
  assign sxmin = $signed({2'b00, xmin});
  assign sxmax = $signed({2'b00, xmax});
  assign symin = $signed({2'b00, ymin});
  assign symax = $signed({2'b00, ymax});

  // Step unit: one cell per cycle in the stored direction
  always_comb begin
    dx = 5'sd0;
    dy = 5'sd0;
    case (dir_r)
      KIND_UP[1:0]:    dy = -5'sd1;
      KIND_DOWN[1:0]:  dy = 5'sd1;
      KIND_LEFT[1:0]:  dx = -5'sd1;
      KIND_RIGHT[1:0]: dx = 5'sd1;
      default:         dx = 5'sd0;
    endcase
  end

  assign cand_x       = nx_r + dx;
  assign cand_y       = ny_r + dy;
  assign cand_in_box  = (cand_x >= sxmin) && (cand_x <= sxmax) &&
                        (cand_y >= symin) && (cand_y <= symax);
  assign cand_blocked = blocked_r[{cand_y[2:0], cand_x[2:0]}];

  // Sequencer next state
  always_comb begin
    logic       ok;
    logic [2:0] tx, ty;
    state_nxt = state_r;
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    sel_nxt   = sel_r;
    live_nxt  = live_r;
    moved_nxt = moved_r;
    nx_nxt    = nx_r;
    ny_nxt    = ny_r;
    dir_nxt   = dir_r;
    pass_nxt  = pass_r;
    ok        = 1'b0;
    tx        = pos_x_r;
    ty        = pos_y_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EMIT;
          moved_nxt = 1'b0;
          case (in_data.kind)
            KIND_UP, KIND_DOWN, KIND_LEFT, KIND_RIGHT: begin
              if (live_r) begin
                state_nxt = S_STEP;
                nx_nxt    = $signed({2'b00, pos_x_r});
                ny_nxt    = $signed({2'b00, pos_y_r});
                dir_nxt   = in_data.kind[1:0];
                pass_nxt  = 1'b0;
              end
            end
            KIND_SELECT: begin
              sel_nxt = do_select(sel_r, pos_x_r, pos_y_r, live_r, sk);
            end
            KIND_RESELECT: begin
              if (live_r) begin
                ok = can_place(sel_r.prior_x, sel_r.prior_y, xmin, xmax, ymin, ymax,
                               blocked_r);
                if (ok) begin
                  tx = sel_r.prior_x;
                  ty = sel_r.prior_y;
                end
                pos_x_nxt = tx;
                pos_y_nxt = ty;
                moved_nxt = (tx != pos_x_r) || (ty != pos_y_r);
                sel_nxt   = do_select(sel_r, tx, ty, live_r, sk);
              end
            end
            KIND_ACTIVATE: begin
              if (mode_r <= MODE_LAST_ACT) begin
                live_nxt = !live_r;
              end
            end
            KIND_APPLY: begin
              if (sk != SK_NONE) begin
                if (sk != SK_SELDESEL) begin
                  sel_nxt.pick_x    = pos_x_r;
                  sel_nxt.pick_y    = pos_y_r;
                  sel_nxt.pick_flag = 1'b1;
                end
                live_nxt = (mode_r > MODE_LAST_ACT);
              end
            end
            KIND_PLACE: begin
              ok = can_place(in_data.target_x, in_data.target_y, xmin, xmax, ymin, ymax,
                             blocked_r);
              if (ok) begin
                pos_x_nxt = in_data.target_x;
                pos_y_nxt = in_data.target_y;
                moved_nxt = (in_data.target_x != pos_x_r) ||
                            (in_data.target_y != pos_y_r);
                if (sk == SK_ON_MOVE) begin
                  sel_nxt = do_select(sel_r, in_data.target_x, in_data.target_y,
                                      live_r, sk);
                end
              end
            end
            default: begin
              moved_nxt = 1'b0;
            end
          endcase
        end
      end

      S_STEP: begin
        // Advance one cell; end the pass at the box edge, or at a wall unless jump is set
        logic end_pass;
        end_pass = 1'b0;
        if (cand_in_box) begin
          nx_nxt = cand_x;
          ny_nxt = cand_y;
          if (!cand_blocked) begin
            ok = 1'b1;
          end else if (!jump_r) begin
            end_pass = 1'b1;
          end
        end else begin
          end_pass = 1'b1;
        end

        if (ok) begin
          state_nxt = S_EMIT;
          pos_x_nxt = cand_x[2:0];
          pos_y_nxt = cand_y[2:0];
          moved_nxt = (cand_x[2:0] != pos_x_r) || (cand_y[2:0] != pos_y_r);
          if (sk == SK_ON_MOVE) begin
            sel_nxt = do_select(sel_r, cand_x[2:0], cand_y[2:0], live_r, sk);
          end
        end else if (end_pass) begin
          if (!wrap_r || pass_r) begin
            // Drop the move
            state_nxt = S_EMIT;
          end else begin
            // Re-enter from just outside the opposite edge
            pass_nxt = 1'b1;
            case (dir_r)
              KIND_UP[1:0]:    ny_nxt = symax + 5'sd1;
              KIND_DOWN[1:0]:  ny_nxt = symin - 5'sd1;
              KIND_LEFT[1:0]:  nx_nxt = sxmax + 5'sd1;
              KIND_RIGHT[1:0]: nx_nxt = sxmin - 5'sd1;
              default:         nx_nxt = nx_r;
            endcase
          end
        end
      end

      S_EMIT: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Load the result item once the output register is free
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_acc) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.cursor_x      = pos_x_r;
      out_data_nxt.cursor_y      = pos_y_r;
      out_data_nxt.chosen_x      = sel_r.pick_x;
      out_data_nxt.chosen_y      = sel_r.pick_y;
      out_data_nxt.chosen_valid  = sel_r.pick_flag;
      out_data_nxt.cursor_active = live_r;
      out_data_nxt.cursor_moved  = moved_r;
    end
  end

  // Hold state, navigator registers, result register and step unit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      sel_r       <= '0;
      live_r      <= 1'b0;
      moved_r     <= 1'b0;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      sel_r       <= sel_nxt;
      live_r      <= live_nxt;
      moved_r     <= moved_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
    nx_r  <= nx_nxt;
    ny_r  <= ny_nxt;
    dir_r <= dir_nxt;
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 3'd0;
      left_r    <= 3'd0;
      right_r   <= 3'd2;
      top_r     <= 3'd0;
      bottom_r  <= 3'd2;
      wrap_r    <= 1'b0;
      jump_r    <= 1'b1;
      blocked_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE:    mode_r    <= cfg_data[2:0];
        CFG_LEFT:    left_r    <= cfg_data[2:0];
        CFG_RIGHT:   right_r   <= cfg_data[2:0];
        CFG_TOP:     top_r     <= cfg_data[2:0];
        CFG_BOTTOM:  bottom_r  <= cfg_data[2:0];
        CFG_WRAP:    wrap_r    <= cfg_data[0];
        CFG_JUMP:    jump_r    <= cfg_data[0];
        CFG_BLOCKED: blocked_r <= cfg_data;
        default:     mode_r    <= mode_r;
      endcase
    end
  end

  // A stalled result holds until taken
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("pending result changed or dropped while stalled");

  // Only an active cursor walks the step unit
  a_step_needs_live : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STEP) |-> live_r)
    else $error("step unit running while cursor inactive");

  // Cursor holds while the step unit walks
  a_pos_stable_in_step : assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_STEP) && $past(state_r == S_STEP)) |->
      ($stable(pos_x_r) && $stable(pos_y_r)))
    else $error("cursor changed in the middle of a move");

  // One result per item
  a_one_result : assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && !load_out) |=> !out_valid)
    else $error("result repeated after being taken");

endmodule

`default_nettype wire
